// File: rtl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// i2cts_pkg: shared types and constants of the temperature sensor registers
// Command codes, register map addresses, ID values and the item and result
// structs that pass between the pipeline and the register core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cts_pkg;

	// Largest channel count the register map can address
	localparam int MAX_SENSORS_DEF = 4;

	// Fixed ID registers, reset value of the high limits and the read fill byte
	localparam logic [7:0] ID_THREE    = 8'h21;
	localparam logic [7:0] ID_FOUR     = 8'h25;
	localparam logic [7:0] MAKER_ID    = 8'h5D;
	localparam logic [7:0] REV_ID      = 8'h04;
	localparam logic [7:0] LIMIT_RESET = 8'h55;
	localparam logic [7:0] READ_FILL   = 8'hFF;

	// Pointer values of the ID registers
	localparam logic [7:0] ADDR_DEV_ID   = 8'hFD;
	localparam logic [7:0] ADDR_MAKER_ID = 8'hFE;
	localparam logic [7:0] ADDR_REV_ID   = 8'hFF;

	// Sensor counts of the two parts
	localparam logic [2:0] COUNT_THREE = 3'd3;
	localparam logic [2:0] COUNT_FOUR  = 3'd4;

	typedef enum logic [2:0] {
		CMD_START_RX = 3'd0,
		CMD_EVENT    = 3'd1,
		CMD_WRITE    = 3'd2,
		CMD_READ     = 3'd3,
		CMD_SET_TEMP = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic [2:0] sensor_index;
		logic [7:0] temp_degrees;
	} item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       index_error;
	} result_t;

	// Register map: temperature of each channel (read only)
	function automatic logic [7:0] temp_addr(input logic [1:0] ch);
		logic [7:0] a;
		case (ch)
			2'd0:    a = 8'h00;
			2'd1:    a = 8'h01;
			2'd2:    a = 8'h23;
			default: a = 8'h2A;
		endcase
		return a;
	endfunction

	// Register map: high limit of each channel
	function automatic logic [7:0] high_addr(input logic [1:0] ch);
		logic [7:0] a;
		case (ch)
			2'd0:    a = 8'h05;
			2'd1:    a = 8'h07;
			2'd2:    a = 8'h15;
			default: a = 8'h2C;
		endcase
		return a;
	endfunction

	// Register map: low limit of each channel
	function automatic logic [7:0] low_addr(input logic [1:0] ch);
		logic [7:0] a;
		case (ch)
			2'd0:    a = 8'h06;
			2'd1:    a = 8'h08;
			2'd2:    a = 8'h16;
			default: a = 8'h2D;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// File: rtl/i2cts_reg_core.sv
// ----------------------------------------------------------------------------
// i2cts_reg_core: register state and item decode
// Holds pointer, transfer flag, read latch, temperatures and limits, and
// works out the result of the item sitting in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cts_reg_core
	import i2cts_pkg::*;
#(
	parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata,
	input  wire logic    fire,
	input  wire item_t   item,
	output result_t      res
);

	logic       variant_q;
	logic [7:0] reg_pointer_q;
	logic       byte_seen_q;
	logic [7:0] read_latch_q;
	logic [7:0] temps_q [MAX_SENSORS];
	logic [7:0] lows_q  [MAX_SENSORS];
	logic [7:0] highs_q [MAX_SENSORS];

	logic [7:0] fetch_val;
	logic [2:0] sensor_cnt;
	logic       idx_bad;
	logic       high_hit [MAX_SENSORS];
	logic       low_hit  [MAX_SENSORS];
	logic       store_hit;
	cmd_t       cmd;

	assign cmd = cmd_t'(item.command);

	// Sensor count of the part, capped at the built channel count
	always_comb begin
		sensor_cnt = variant_q ? COUNT_FOUR : COUNT_THREE;
		if (sensor_cnt > 3'(MAX_SENSORS)) begin
			sensor_cnt = 3'(MAX_SENSORS);
		end
	end

	assign idx_bad = (item.sensor_index >= sensor_cnt);

	// Register read at the current pointer; unmapped reads as zero
	always_comb begin
		fetch_val = '0;
		if (reg_pointer_q == ADDR_DEV_ID) begin
			fetch_val = variant_q ? ID_FOUR : ID_THREE;
		end else if (reg_pointer_q == ADDR_MAKER_ID) begin
			fetch_val = MAKER_ID;
		end else if (reg_pointer_q == ADDR_REV_ID) begin
			fetch_val = REV_ID;
		end else begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				if (reg_pointer_q == temp_addr(2'(i))) fetch_val = temps_q[i];
				if (reg_pointer_q == high_addr(2'(i))) fetch_val = highs_q[i];
				if (reg_pointer_q == low_addr(2'(i)))  fetch_val = lows_q[i];
			end
		end
	end

	// Limit register hits for a data byte
	always_comb begin
		store_hit = 1'b0;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			high_hit[i] = (reg_pointer_q == high_addr(2'(i)));
			low_hit[i]  = (reg_pointer_q == low_addr(2'(i)));
			store_hit   = store_hit | high_hit[i] | low_hit[i];
		end
	end

	// Result of the item
	always_comb begin
		res = '0;
		unique case (cmd)
			CMD_READ:     res.read_byte   = byte_seen_q ? READ_FILL : read_latch_q;
			CMD_SET_TEMP: res.index_error = idx_bad;
			default:      res = '0;
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b1;
		end else if (cfg_we) begin
			variant_q <= cfg_wdata;
		end
	end

	// Bus state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_pointer_q <= '0;
			byte_seen_q   <= 1'b0;
			read_latch_q  <= '0;
		end else if (fire) begin
			unique case (cmd)
				CMD_START_RX: begin
					read_latch_q <= fetch_val;
					byte_seen_q  <= 1'b0;
				end
				CMD_EVENT: begin
					byte_seen_q <= 1'b0;
				end
				CMD_WRITE: begin
					if (!byte_seen_q) begin
						reg_pointer_q <= item.byte_value;
						byte_seen_q   <= 1'b1;
					end else begin
						read_latch_q <= store_hit ? item.byte_value : 8'h00;
					end
				end
				CMD_READ: begin
					byte_seen_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-channel temperature and limit registers
	for (genvar g = 0; g < MAX_SENSORS; g++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				temps_q[g] <= '0;
				lows_q[g]  <= '0;
				highs_q[g] <= LIMIT_RESET;
			end else if (fire) begin
				if (cmd == CMD_SET_TEMP && !idx_bad && item.sensor_index == 3'(g)) begin
					temps_q[g] <= item.temp_degrees;
				end
				if (cmd == CMD_WRITE && byte_seen_q && high_hit[g]) begin
					highs_q[g] <= item.byte_value;
				end
				if (cmd == CMD_WRITE && byte_seen_q && low_hit[g]) begin
					lows_q[g] <= item.byte_value;
				end
			end
		end
	end

	// A start-receive ends the transfer
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd == CMD_START_RX |=> !byte_seen_q)
		else $error("transfer flag survives start-receive");

	// Any moved byte opens the transfer
	a_byte_sets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd == CMD_WRITE || cmd == CMD_READ) |=> byte_seen_q)
		else $error("transfer flag not set after byte");

	// Only a temperature update can flag an index error
	a_err_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res.index_error |-> cmd == CMD_SET_TEMP)
		else $error("index error on wrong command");

endmodule

`default_nettype wire

// File: rtl/i2c_temp_sensor_register_file_core.sv
// ----------------------------------------------------------------------------
// i2c_temp_sensor_register_file_core: temperature sensor target registers
// Input register, register core and result register of the I2C target's
// register file; one result item for every input item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | command, byte_value,
//          |           |                     | sensor_index, temp_degrees
//  out     | out       | out_valid/out_stall | read_byte, index_error
//  cfg     | in        | cfg_we              | cfg_wdata (variant)
//
// One item per cycle while out_stall is low; each item passes the input
// register, then decode and state update into the result register.
// Reset puts the variant at the four-sensor part and clears the valid bits
// and the register state, high limits at 0x55.
// in_stall rises only when both the input and the result register hold an
// item and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_temp_sensor_register_file_core
	import i2cts_pkg::*;
#(
	parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] command,
	input  wire logic [7:0] byte_value,
	input  wire logic [2:0] sensor_index,
	input  wire logic [7:0] temp_degrees,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_byte,
	output logic            index_error
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_c;
	logic    advance;
	logic    take_in;
	logic    fire;

	// Handshake and pipeline advance
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{command: command, byte_value: byte_value,
				sensor_index: sensor_index, temp_degrees: temp_degrees};
		end
	end

	i2cts_reg_core #(
		.MAX_SENSORS (MAX_SENSORS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid   = valid_s2;
	assign read_byte   = res_s2.read_byte;
	assign index_error = res_s2.index_error;

	// Stall back to the input only with both registers full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	// A held input item is not lost
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register dropped a stalled item");

	// A result carries at most one kind of answer
	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(index_error && read_byte != 8'h00))
		else $error("read byte and index error together");

	// Every item processed reaches the result register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed item missing from result register");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for the temperature sensor register file core
// Drives bus events, register bytes and temperature updates through the
// valid/stall input, predicts each response with a local copy of the
// register map and checks every result item in order. Both sides idle and
// stall at random, and the receiver holds off once to fill the block.
// ----------------------------------------------------------------------------

module tb;
	import i2cts_pkg::*;

	// Register map of the part, channel 0 in the low byte
	localparam logic [3:0][7:0] TEMP_MAP = {8'h2A, 8'h23, 8'h01, 8'h00};
	localparam logic [3:0][7:0] HIGH_MAP = {8'h2C, 8'h15, 8'h07, 8'h05};
	localparam logic [3:0][7:0] LOW_MAP  = {8'h2D, 8'h16, 8'h08, 8'h06};

	localparam logic [7:0] PTR_DEV_ID   = 8'hFD;
	localparam logic [7:0] PTR_MAKER    = 8'hFE;
	localparam logic [7:0] PTR_REVISION = 8'hFF;
	localparam logic [7:0] PTR_UNMAPPED = 8'h80;

	localparam logic [7:0] DEV_ID_THREE = 8'h21;
	localparam logic [7:0] DEV_ID_FOUR  = 8'h25;
	localparam logic [7:0] MAKER_CODE   = 8'h5D;
	localparam logic [7:0] REVISION     = 8'h04;
	localparam logic [7:0] HIGH_DEFAULT = 8'h55;
	localparam logic [7:0] FILL_BYTE    = 8'hFF;

	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	localparam int NUM_CH         = 4;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 3;
	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] command;
	logic [7:0] byte_value;
	logic [2:0] sensor_index;
	logic [7:0] temp_degrees;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_byte;
	logic       index_error;

	// Predicted register state
	logic       variant_q;
	logic [7:0] ptr_q;
	logic       byte_seen_q;
	logic [7:0] latch_q;
	logic [7:0] temps [NUM_CH];
	logic [7:0] lows  [NUM_CH];
	logic [7:0] highs [NUM_CH];

	result_t expected_results [$];

	int mismatches;
	int items_sent;
	int quiet_cycles;
	int gap_pct;
	int stall_pct;
	bit hold_req;
	bit hold_active;

	i2c_temp_sensor_register_file_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.byte_value   (byte_value),
		.sensor_index (sensor_index),
		.temp_degrees (temp_degrees),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_byte    (read_byte),
		.index_error  (index_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Register map prediction
	// ------------------------------------------------------------------
	function automatic int channel_count();
		int n;
		n = variant_q ? 4 : 3;
		return (n > NUM_CH) ? NUM_CH : n;
	endfunction

	function automatic logic [7:0] reg_lookup(input logic [7:0] p);
		if (p == PTR_DEV_ID)
			return variant_q ? DEV_ID_FOUR : DEV_ID_THREE;
		if (p == PTR_MAKER)
			return MAKER_CODE;
		if (p == PTR_REVISION)
			return REVISION;
		for (int i = 0; i < NUM_CH; i++) begin
			if (p == TEMP_MAP[i])
				return temps[i];
			if (p == HIGH_MAP[i])
				return highs[i];
			if (p == LOW_MAP[i])
				return lows[i];
		end
		return 8'h00;
	endfunction

	// data byte: only limit registers take it, the latch mirrors the result
	function automatic void reg_store(input logic [7:0] p, input logic [7:0] v);
		for (int i = 0; i < NUM_CH; i++) begin
			if (p == HIGH_MAP[i]) begin
				highs[i] = v;
				latch_q = v;
				return;
			end
			if (p == LOW_MAP[i]) begin
				lows[i] = v;
				latch_q = v;
				return;
			end
		end
		latch_q = 8'h00;
	endfunction

	function automatic result_t predict_response(input logic [2:0] cmd, input logic [7:0] b,
		input logic [2:0] idx, input logic [7:0] t);
		result_t r;
		r = '0;
		case (cmd)
			CMD_START_RX: begin
				latch_q = reg_lookup(ptr_q);
				byte_seen_q = 1'b0;
			end
			CMD_EVENT: begin
				byte_seen_q = 1'b0;
			end
			CMD_WRITE: begin
				if (!byte_seen_q) begin
					ptr_q = b;
					byte_seen_q = 1'b1;
				end else begin
					reg_store(ptr_q, b);
				end
			end
			CMD_READ: begin
				if (!byte_seen_q) begin
					byte_seen_q = 1'b1;
					r.read_byte = latch_q;
				end else begin
					r.read_byte = FILL_BYTE;
				end
			end
			CMD_SET_TEMP: begin
				if (int'(idx) >= channel_count())
					r.index_error = 1'b1;
				else
					temps[idx[1:0]] = t;
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(9, 0) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 0);
	endfunction

	// mostly mapped registers, some arbitrary pointers
	function automatic logic [7:0] pick_pointer();
		int r;
		r = $urandom_range(19, 0);
		if (r < 4)
			return TEMP_MAP[2'(r)];
		if (r < 8)
			return HIGH_MAP[2'(r - 4)];
		if (r < 12)
			return LOW_MAP[2'(r - 8)];
		if (r == 12)
			return PTR_DEV_ID;
		if (r == 13)
			return PTR_MAKER;
		if (r == 14)
			return PTR_REVISION;
		return 8'($urandom_range(255, 0));
	endfunction

	// valid stays high on return; the next call or wait_idle follows
	// in the same time step
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] b,
		input logic [2:0] idx, input logic [7:0] t);
		int gap;
		gap = ($urandom_range(99, 0) < gap_pct) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		byte_value   <= b;
		sensor_index <= idx;
		temp_degrees <= t;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_response(cmd, b, idx, t));
		items_sent++;
	endtask

	task automatic send_bus(input logic [2:0] cmd, input logic [7:0] b);
		send_item(cmd, b, 3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)));
	endtask

	task automatic send_temp(input logic [2:0] idx, input logic [7:0] t);
		send_item(CMD_SET_TEMP, 8'($urandom_range(255, 0)), idx, t);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_variant(input logic v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		variant_q = v;
	endtask

	// one bus transfer, a temperature update or a noise item
	task automatic random_transfer();
		int kind;
		kind = $urandom_range(99, 0);
		if (kind < 35) begin
			send_bus(CMD_EVENT, 8'($urandom_range(255, 0)));
			send_bus(CMD_WRITE, pick_pointer());
			repeat ($urandom_range(3, 0))
				send_bus(CMD_WRITE, 8'($urandom_range(255, 0)));
			send_bus(CMD_EVENT, 8'($urandom_range(255, 0)));
		end else if (kind < 70) begin
			send_bus(CMD_EVENT, 8'($urandom_range(255, 0)));
			if ($urandom_range(4, 0) != 0)
				send_bus(CMD_WRITE, pick_pointer());
			send_bus(CMD_START_RX, 8'($urandom_range(255, 0)));
			repeat ($urandom_range(3, 1))
				send_bus(CMD_READ, 8'($urandom_range(255, 0)));
			send_bus(CMD_EVENT, 8'($urandom_range(255, 0)));
		end else if (kind < 85) begin
			send_temp(3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)));
		end else begin
			send_item(3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)),
				3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_id_registers();
		send_bus(CMD_WRITE, PTR_DEV_ID);
		send_bus(CMD_START_RX, 8'h00);
		send_bus(CMD_READ, 8'h00);
		send_bus(CMD_READ, 8'hFF);
		send_bus(CMD_EVENT, 8'h00);
		send_bus(CMD_WRITE, PTR_REVISION);
		send_bus(CMD_START_RX, 8'hFF);
		send_bus(CMD_READ, 8'h00);
	endtask

	// write a limit, then read it back; no auto-increment
	task automatic test_limit_registers();
		send_bus(CMD_EVENT, 8'h00);
		send_bus(CMD_WRITE, LOW_MAP[3]);
		send_bus(CMD_WRITE, 8'hAA);
		send_bus(CMD_START_RX, 8'h00);
		send_bus(CMD_READ, 8'h00);
	endtask

	task automatic test_temperature_updates();
		send_temp(3'd0, 8'hFF);
		send_temp(3'd3, 8'h00);
		send_temp(3'd4, 8'h5A);
		send_temp(3'd7, 8'hA5);
	endtask

	// unmapped pointer, write after read, read after write, unused codes
	task automatic test_transfer_corners();
		send_bus(CMD_EVENT, 8'h00);
		send_bus(CMD_WRITE, PTR_UNMAPPED);
		send_bus(CMD_START_RX, 8'h00);
		send_bus(CMD_READ, 8'h00);
		send_bus(CMD_WRITE, 8'h12);
		send_bus(CMD_READ, 8'h00);
		send_item(CMD_UNUSED_FIRST, 8'hFF, 3'd7, 8'hFF);
		send_item(CMD_UNUSED_LAST, 8'h00, 3'd0, 8'h00);
	endtask

	task automatic test_variant_switch();
		set_variant(1'b0);
		send_temp(3'd3, 8'h7E);
		send_bus(CMD_EVENT, 8'h00);
		send_bus(CMD_WRITE, PTR_DEV_ID);
		send_bus(CMD_START_RX, 8'h00);
		send_bus(CMD_READ, 8'h00);
		set_variant(1'b1);
	endtask

	// receiver holds off while items keep coming until the input stalls
	task automatic test_back_pressure();
		int target;
		wait_idle();
		gap_pct   = 0;
		stall_pct = 0;
		hold_req  = 1'b1;
		wait (hold_active);
		target = items_sent + 30;
		while (items_sent < target)
			random_transfer();
	endtask

	task automatic test_random_traffic(input logic v, input int g_pct, input int s_pct,
		input int n);
		int target;
		set_variant(v);
		gap_pct   = g_pct;
		stall_pct = s_pct;
		target = items_sent + n;
		while (items_sent < target)
			random_transfer();
	endtask

	// ------------------------------------------------------------------
	// Receiver idling and the long hold-off
	// ------------------------------------------------------------------
	initial begin : receiver_idling
		int run;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99, 0) < stall_pct);
				run = pick_gap();
				repeat (run) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", read_byte, 8'h00);
			end else begin
				want = expected_results.pop_front();
				if (read_byte !== want.read_byte)
					report_mismatch("read_byte", read_byte, want.read_byte);
				if (index_error !== want.index_error)
					report_mismatch("index_error", 8'(index_error),
						8'(want.index_error));
			end
		end
	end

	// cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("i2c_temp_sensor_register_file_core regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_EVENT;
		byte_value   = 8'h00;
		sensor_index = 3'd0;
		temp_degrees = 8'h00;
		mismatches   = 0;
		items_sent   = 0;
		quiet_cycles = 0;
		gap_pct      = 30;
		stall_pct    = 30;
		hold_req     = 1'b0;
		hold_active  = 1'b0;

		// reset state of the part
		variant_q   = 1'b1;
		ptr_q       = 8'h00;
		byte_seen_q = 1'b0;
		latch_q     = 8'h00;
		for (int i = 0; i < NUM_CH; i++) begin
			temps[i] = 8'h00;
			lows[i]  = 8'h00;
			highs[i] = HIGH_DEFAULT;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_id_registers();
		test_limit_registers();
		test_temperature_updates();
		test_transfer_corners();
		test_variant_switch();
		test_back_pressure();
		test_random_traffic(1'b1, 30, 30, 350);
		test_random_traffic(1'b0, 40, 20, 350);
		test_random_traffic(1'b0, 0, 0, 350);
		test_random_traffic(1'b1, 70, 60, 350);

		wait_idle();
		if (mismatches == 0)
			$display("i2c_temp_sensor_register_file_core regression: pass");
		else
			$display("i2c_temp_sensor_register_file_core regression: fail");
		$finish;
	end

endmodule
